/* design/assert_macros.svh */
// assertion helpers shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SNDCAG_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SNDCAG_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define SNDCAG_ASSERT(lbl, clk, rst, prop, msg)
`define SNDCAG_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

/* design/sndcag_pkg.sv */
package sndcag_pkg;

   localparam int ACTION_BITS    = 2;
   localparam int DIM_IDX_BITS   = 4;
   localparam int FIELD_BITS     = 16;
   localparam int OUT_ADDR_BITS  = 32;
   localparam int RANK_BITS      = 5;
   localparam int ELEM_BITS      = 5;
   localparam int CSR_DATA_BITS  = 5;
   localparam int CSR_INDEX_BITS = 1;
   // stride times element size
   localparam int SCALED_BITS    = FIELD_BITS + ELEM_BITS;

   localparam logic [ACTION_BITS-1:0] ACT_LOAD  = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_START = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_STEP  = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_RANK       = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ELEM_BYTES = 1'd1;

   localparam logic [ELEM_BITS-1:0] ELEM_BYTES_RESET = 5'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP_MUL,
      ST_PREP_REW,
      ST_PREP_WR,
      ST_ADV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic prep_mul;
      logic prep_rew;
      logic prep_wr;
      logic capture;
      logic adv;
      logic load_out;
      logic last;
      logic cfg_lock;
   } cmd_type;

   typedef struct packed {
      logic idx_ok;
      logic ext_zero;
      logic wrap;
      logic out_free;
   } sts_type;

endpackage

/* design/sndcag_req_if.sv */
interface sndcag_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [sndcag_pkg::ACTION_BITS-1:0]   action;
   logic [sndcag_pkg::DIM_IDX_BITS-1:0]  dim_index;
   logic [sndcag_pkg::FIELD_BITS-1:0]    extent;
   logic [sndcag_pkg::FIELD_BITS-1:0]    src_stride;
   logic [sndcag_pkg::FIELD_BITS-1:0]    dst_stride;

   modport source (
      output valid, action, dim_index, extent, src_stride, dst_stride,
      input  ready
   );
   modport sink (
      input  valid, action, dim_index, extent, src_stride, dst_stride,
      output ready
   );
endinterface

/* design/sndcag_rsp_if.sv */
interface sndcag_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [sndcag_pkg::OUT_ADDR_BITS-1:0] src_addr;
   logic [sndcag_pkg::OUT_ADDR_BITS-1:0] dst_addr;
   logic                                 last;

   modport source (
      output valid, src_addr, dst_addr, last,
      input  ready
   );
   modport sink (
      input  valid, src_addr, dst_addr, last,
      output ready
   );
endinterface

/* design/strided_nd_copy_address_gen_top.sv */
// Address generator for a strided N-dimensional copy.
// req_ch carries one request per handshake: load a dimension descriptor,
// start a walk, or step to the next element. rsp_ch returns one source and
// destination byte offset per step of an armed walk, with last on the final
// element. csr_wen/csr_index/csr_wdata write rank and element size; writes
// are ignored while a walk is armed.
// A load request is written straight from idle. A start request runs a
// descriptor pass over the n dimensions in use (rank, at most MAX_DIMS),
// visiting each dimension in turn: it scales the strides by the element size,
// then forms the extent times stride rewind, then the wrap delta, with a
// register after each multiplier.
// A step request walks the carry chain through k dimensions, k the number
// the carry touches (1 to n), one dimension per cycle.
// rsp_ch has an output register: new requests are taken while a result is
// still pending; a finished step waits in its own state only if the
// previous result has not been taken.
// Reset is synchronous: rank 0, element size 4, offsets and coordinates
// zero, no walk armed. Descriptors hold nothing until loaded.
module strided_nd_copy_address_gen_top #(
   parameter int MAX_DIMS    = 16,
   parameter int ADDR_BITS   = 32,
   parameter int EXTENT_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   sndcag_req_if.sink                            req_ch,
   sndcag_rsp_if.source                          rsp_ch,
   input  logic                                  csr_wen,
   input  logic [sndcag_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sndcag_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int DIM_BITS = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int CNT_BITS = $clog2(MAX_DIMS + 1);

   sndcag_pkg::cmd_type cmd;
   sndcag_pkg::sts_type sts;
   logic [DIM_BITS-1:0] dim;
   logic [CNT_BITS-1:0] n_dims;

   sndcag_ctrl #(
      .MAX_DIMS (MAX_DIMS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_action (req_ch.action),
      .req_ready  (req_ch.ready),
      .sts        (sts),
      .n_dims     (n_dims),
      .cmd        (cmd),
      .dim        (dim)
   );

   sndcag_dpath #(
      .MAX_DIMS    (MAX_DIMS),
      .ADDR_BITS   (ADDR_BITS),
      .EXTENT_BITS (EXTENT_BITS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .dim           (dim),
      .sts           (sts),
      .n_dims        (n_dims),
      .csr_wen       (csr_wen),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .ld_index      (req_ch.dim_index),
      .ld_extent     (req_ch.extent),
      .ld_src_stride (req_ch.src_stride),
      .ld_dst_stride (req_ch.dst_stride),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_src_addr  (rsp_ch.src_addr),
      .rsp_dst_addr  (rsp_ch.dst_addr),
      .rsp_last      (rsp_ch.last)
   );

endmodule

/* design/sndcag_ctrl.sv */
`include "assert_macros.svh"

module sndcag_ctrl #(
   parameter int MAX_DIMS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic [sndcag_pkg::ACTION_BITS-1:0]  req_action,
   output logic                                req_ready,
   input  sndcag_pkg::sts_type                 sts,
   input  logic [$clog2(MAX_DIMS+1)-1:0]       n_dims,
   output sndcag_pkg::cmd_type                 cmd,
   output logic [((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1)-1:0] dim
);

   localparam int DIM_BITS = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int CNT_BITS = $clog2(MAX_DIMS + 1);

   sndcag_pkg::state_type state_ff, state_in;
   logic [DIM_BITS-1:0]   dim_ff, dim_in;
   logic                  walk_active_ff, walk_active_in;
   logic                  ok_ff, ok_in;
   logic                  last_ff, last_in;
   logic [CNT_BITS-1:0]   n_m1;
   logic [DIM_BITS-1:0]   dim_last;

   assign n_m1     = n_dims - CNT_BITS'(1);
   assign dim_last = DIM_BITS'(n_m1);
   assign dim      = dim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= sndcag_pkg::ST_IDLE;
         dim_ff         <= '0;
         walk_active_ff <= 1'b0;
         ok_ff          <= 1'b0;
         last_ff        <= 1'b0;
      end else begin
         state_ff       <= state_in;
         dim_ff         <= dim_in;
         walk_active_ff <= walk_active_in;
         ok_ff          <= ok_in;
         last_ff        <= last_in;
      end
   end

   always_comb begin
      logic done;
      logic fin;
      done           = 1'b0;
      fin            = 1'b0;
      state_in       = state_ff;
      dim_in         = dim_ff;
      walk_active_in = walk_active_ff;
      ok_in          = ok_ff;
      last_in        = last_ff;
      cmd            = '0;
      cmd.cfg_lock   = walk_active_ff;
      req_ready      = 1'b0;
      case (state_ff)
         sndcag_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_action)
                  sndcag_pkg::ACT_LOAD: begin
                     if (!walk_active_ff && sts.idx_ok) begin
                        cmd.load = 1'b1;
                     end
                  end
                  sndcag_pkg::ACT_START: begin
                     cmd.clear      = 1'b1;
                     walk_active_in = 1'b0;
                     if (n_dims != '0) begin
                        dim_in   = '0;
                        ok_in    = 1'b1;
                        state_in = sndcag_pkg::ST_PREP_MUL;
                     end
                  end
                  sndcag_pkg::ACT_STEP: begin
                     if (walk_active_ff) begin
                        cmd.capture = 1'b1;
                        dim_in      = dim_last;
                        state_in    = sndcag_pkg::ST_ADV;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         sndcag_pkg::ST_PREP_MUL: begin
            cmd.prep_mul = 1'b1;
            if (sts.ext_zero) begin
               ok_in = 1'b0;
            end
            state_in = sndcag_pkg::ST_PREP_REW;
         end
         sndcag_pkg::ST_PREP_REW: begin
            cmd.prep_rew = 1'b1;
            state_in     = sndcag_pkg::ST_PREP_WR;
         end
         sndcag_pkg::ST_PREP_WR: begin
            cmd.prep_wr = 1'b1;
            if (dim_ff == dim_last) begin
               walk_active_in = ok_ff;
               state_in       = sndcag_pkg::ST_IDLE;
            end else begin
               dim_in   = dim_ff + DIM_BITS'(1);
               state_in = sndcag_pkg::ST_PREP_MUL;
            end
         end
         sndcag_pkg::ST_ADV: begin
            cmd.adv = 1'b1;
            if (!sts.wrap) begin
               done = 1'b1;
            end else if (dim_ff == '0) begin
               done           = 1'b1;
               fin            = 1'b1;
               walk_active_in = 1'b0;
            end else begin
               dim_in = dim_ff - DIM_BITS'(1);
            end
            if (done) begin
               if (sts.out_free) begin
                  cmd.load_out = 1'b1;
                  cmd.last     = fin;
                  state_in     = sndcag_pkg::ST_IDLE;
               end else begin
                  last_in  = fin;
                  state_in = sndcag_pkg::ST_EMIT;
               end
            end
         end
         sndcag_pkg::ST_EMIT: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               cmd.last     = last_ff;
               state_in     = sndcag_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sndcag_pkg::ST_IDLE;
         end
      endcase
   end

   `SNDCAG_ASSERT(a_walk_arm, clock, reset, $rose(walk_active_ff) |-> $past(state_ff == sndcag_pkg::ST_PREP_WR), "walk armed outside the descriptor pass")
   `SNDCAG_ASSERT(a_adv_armed, clock, reset, (state_ff == sndcag_pkg::ST_ADV) |-> walk_active_ff, "advance without an armed walk")
   `SNDCAG_ASSERT(a_adv_dim, clock, reset, (state_ff == sndcag_pkg::ST_ADV) |-> (CNT_BITS'(dim_ff) < n_dims), "advance beyond the dimensions in use")

endmodule

/* design/sndcag_dpath.sv */
`include "assert_macros.svh"

module sndcag_dpath #(
   parameter int MAX_DIMS    = 16,
   parameter int ADDR_BITS   = 32,
   parameter int EXTENT_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sndcag_pkg::cmd_type                   cmd,
   input  logic [((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1)-1:0] dim,
   output sndcag_pkg::sts_type                   sts,
   output logic [$clog2(MAX_DIMS+1)-1:0]         n_dims,
   input  logic                                  csr_wen,
   input  logic [sndcag_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sndcag_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic [sndcag_pkg::DIM_IDX_BITS-1:0]   ld_index,
   input  logic [sndcag_pkg::FIELD_BITS-1:0]     ld_extent,
   input  logic [sndcag_pkg::FIELD_BITS-1:0]     ld_src_stride,
   input  logic [sndcag_pkg::FIELD_BITS-1:0]     ld_dst_stride,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [sndcag_pkg::OUT_ADDR_BITS-1:0]  rsp_src_addr,
   output logic [sndcag_pkg::OUT_ADDR_BITS-1:0]  rsp_dst_addr,
   output logic                                  rsp_last
);

   localparam int DIM_BITS = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int CNT_BITS = $clog2(MAX_DIMS + 1);
   localparam int SC_BITS  = sndcag_pkg::SCALED_BITS;
   localparam int REW_BITS = EXTENT_BITS + SC_BITS;
   localparam int FB       = sndcag_pkg::FIELD_BITS;
   localparam int OB       = sndcag_pkg::OUT_ADDR_BITS;

   // configuration
   logic [sndcag_pkg::RANK_BITS-1:0] rank_ff, rank_in;
   logic [sndcag_pkg::ELEM_BITS-1:0] elem_ff, elem_in;

   // descriptors
   logic [EXTENT_BITS-1:0] ext_ff [MAX_DIMS];
   logic [EXTENT_BITS-1:0] ext_in [MAX_DIMS];
   logic [FB-1:0]          sstr_ff [MAX_DIMS];
   logic [FB-1:0]          sstr_in [MAX_DIMS];
   logic [FB-1:0]          dstr_ff [MAX_DIMS];
   logic [FB-1:0]          dstr_in [MAX_DIMS];

   // byte steps and wrap deltas
   logic [ADDR_BITS-1:0] sstep_ff [MAX_DIMS];
   logic [ADDR_BITS-1:0] sstep_in [MAX_DIMS];
   logic [ADDR_BITS-1:0] dstep_ff [MAX_DIMS];
   logic [ADDR_BITS-1:0] dstep_in [MAX_DIMS];
   logic [ADDR_BITS-1:0] swrap_ff [MAX_DIMS];
   logic [ADDR_BITS-1:0] swrap_in [MAX_DIMS];
   logic [ADDR_BITS-1:0] dwrap_ff [MAX_DIMS];
   logic [ADDR_BITS-1:0] dwrap_in [MAX_DIMS];

   logic [EXTENT_BITS-1:0] coord_ff [MAX_DIMS];
   logic [EXTENT_BITS-1:0] coord_in [MAX_DIMS];

   logic [SC_BITS-1:0]   ss_ff, ss_in, ds_ff, ds_in;
   logic [ADDR_BITS-1:0] srew_ff, srew_in, drew_ff, drew_in;
   logic [ADDR_BITS-1:0] src_off_ff, src_off_in, dst_off_ff, dst_off_in;
   logic [ADDR_BITS-1:0] res_src_ff, res_src_in, res_dst_ff, res_dst_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [OB-1:0] rsp_src_ff, rsp_src_in, rsp_dst_ff, rsp_dst_in;
   logic          rsp_last_ff, rsp_last_in;

   logic [DIM_BITS-1:0]    ld_dim;
   logic [SC_BITS-1:0]     sprod, dprod;
   logic [REW_BITS-1:0]    srew_full, drew_full;
   logic [EXTENT_BITS-1:0] coord_nxt;

   assign ld_dim    = DIM_BITS'(ld_index);
   assign sprod     = SC_BITS'(sstr_ff[dim]) * SC_BITS'(elem_ff);
   assign dprod     = SC_BITS'(dstr_ff[dim]) * SC_BITS'(elem_ff);
   assign srew_full = REW_BITS'(ext_ff[dim]) * REW_BITS'(ss_ff);
   assign drew_full = REW_BITS'(ext_ff[dim]) * REW_BITS'(ds_ff);
   assign coord_nxt = coord_ff[dim] + EXTENT_BITS'(1);

   assign n_dims = (int'(rank_ff) > MAX_DIMS) ? CNT_BITS'(MAX_DIMS) : CNT_BITS'(rank_ff);

   always_comb begin
      sts          = '0;
      sts.idx_ok   = int'(ld_index) < MAX_DIMS;
      sts.ext_zero = ext_ff[dim] == '0;
      sts.wrap     = coord_nxt == ext_ff[dim];
      sts.out_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      rank_in      = rank_ff;
      elem_in      = elem_ff;
      ext_in       = ext_ff;
      sstr_in      = sstr_ff;
      dstr_in      = dstr_ff;
      sstep_in     = sstep_ff;
      dstep_in     = dstep_ff;
      swrap_in     = swrap_ff;
      dwrap_in     = dwrap_ff;
      coord_in     = coord_ff;
      ss_in        = ss_ff;
      ds_in        = ds_ff;
      srew_in      = srew_ff;
      drew_in      = drew_ff;
      src_off_in   = src_off_ff;
      dst_off_in   = dst_off_ff;
      res_src_in   = res_src_ff;
      res_dst_in   = res_dst_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_src_in   = rsp_src_ff;
      rsp_dst_in   = rsp_dst_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_wen && !cmd.cfg_lock) begin
         case (csr_index)
            sndcag_pkg::CSR_RANK:       rank_in = sndcag_pkg::RANK_BITS'(csr_wdata);
            sndcag_pkg::CSR_ELEM_BYTES: elem_in = sndcag_pkg::ELEM_BITS'(csr_wdata);
            default: begin
            end
         endcase
      end

      if (cmd.load) begin
         ext_in[ld_dim]  = EXTENT_BITS'(ld_extent);
         sstr_in[ld_dim] = ld_src_stride;
         dstr_in[ld_dim] = ld_dst_stride;
      end

      if (cmd.clear) begin
         for (int i = 0; i < MAX_DIMS; i++) begin
            coord_in[i] = '0;
         end
         src_off_in = '0;
         dst_off_in = '0;
      end

      // descriptor pass, one dimension over the multiply, rewind and write steps
      if (cmd.prep_mul) begin
         ss_in = sprod;
         ds_in = dprod;
      end
      if (cmd.prep_rew) begin
         srew_in       = ADDR_BITS'(srew_full);
         drew_in       = ADDR_BITS'(drew_full);
         sstep_in[dim] = ADDR_BITS'(ss_ff);
         dstep_in[dim] = ADDR_BITS'(ds_ff);
      end
      if (cmd.prep_wr) begin
         swrap_in[dim] = sstep_ff[dim] - srew_ff;
         dwrap_in[dim] = dstep_ff[dim] - drew_ff;
      end

      if (cmd.capture) begin
         res_src_in = src_off_ff;
         res_dst_in = dst_off_ff;
      end

      // one dimension of the carry chain
      if (cmd.adv) begin
         if (sts.wrap) begin
            coord_in[dim] = '0;
            src_off_in    = src_off_ff + swrap_ff[dim];
            dst_off_in    = dst_off_ff + dwrap_ff[dim];
         end else begin
            coord_in[dim] = coord_nxt;
            src_off_in    = src_off_ff + sstep_ff[dim];
            dst_off_in    = dst_off_ff + dstep_ff[dim];
         end
      end

      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         rsp_src_in   = OB'(res_src_ff);
         rsp_dst_in   = OB'(res_dst_ff);
         rsp_last_in  = cmd.last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff      <= '0;
         elem_ff      <= sndcag_pkg::ELEM_BYTES_RESET;
         src_off_ff   <= '0;
         dst_off_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_DIMS; i++) begin
            coord_ff[i] <= '0;
         end
      end else begin
         rank_ff      <= rank_in;
         elem_ff      <= elem_in;
         src_off_ff   <= src_off_in;
         dst_off_ff   <= dst_off_in;
         rsp_valid_ff <= rsp_valid_in;
         coord_ff     <= coord_in;
      end
   end

   always_ff @(posedge clock) begin
      ext_ff      <= ext_in;
      sstr_ff     <= sstr_in;
      dstr_ff     <= dstr_in;
      sstep_ff    <= sstep_in;
      dstep_ff    <= dstep_in;
      swrap_ff    <= swrap_in;
      dwrap_ff    <= dwrap_in;
      ss_ff       <= ss_in;
      ds_ff       <= ds_in;
      srew_ff     <= srew_in;
      drew_ff     <= drew_in;
      res_src_ff  <= res_src_in;
      res_dst_ff  <= res_dst_in;
      rsp_src_ff  <= rsp_src_in;
      rsp_dst_ff  <= rsp_dst_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_src_addr = rsp_src_ff;
   assign rsp_dst_addr = rsp_dst_ff;
   assign rsp_last     = rsp_last_ff;

   `SNDCAG_ASSERT_NEVER(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_ready && cmd.load_out, "pending result overwritten")

endmodule
